// ----- sv/tcw_pkg.sv -----
// Shared types and constants of the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int CELL_W = 16;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  // A space, white on black.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // What a put word does besides moving the cursor.
  typedef struct packed {
    logic write_cell;
    logic scroll;
  } tcw_step_t;

endpackage
`default_nettype wire

// ----- sv/tcw_cell_ram.sv -----
// Frame buffer memory: one write port and one registered read port.
`default_nettype none
module tcw_cell_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/tcw_cursor.sv -----
// Cursor update for a put word: control codes, printing, wrap and scroll detection.
`default_nettype none
module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic [$clog2(COLUMNS)-1:0] col,
  input  wire logic [$clog2(ROWS)-1:0]    row,
  input  wire logic [7:0]                 char_code,
  output logic      [$clog2(COLUMNS)-1:0] col_next,
  output logic      [$clog2(ROWS)-1:0]    row_next,
  output tcw_step_t                       step
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int CX_W  = $clog2(COLUMNS + TAB_STOP);
  localparam int NTAB  = (COLUMNS + TAB_STOP - 1) / TAB_STOP;

  logic [CX_W-1:0] tab_col;
  logic [CX_W-1:0] cx;
  logic            row_inc;
  logic            printable;

  // Next tab stop: the last stop at or below the column, plus one stop.
  always_comb begin
    tab_col = CX_W'(TAB_STOP);
    for (int k = 0; k < NTAB; k++) begin
      if (CX_W'(col) >= CX_W'(k * TAB_STOP)) begin
        tab_col = CX_W'((k + 1) * TAB_STOP);
      end
    end
  end

  assign printable = (char_code[7] == 1'b0) && (char_code >= CHAR_SPACE);

  always_comb begin
    cx              = CX_W'(col);
    row_inc         = 1'b0;
    step.write_cell = 1'b0;
    priority if (char_code == CHAR_BACKSPACE) begin
      if (col != '0) begin
        cx = cx - CX_W'(1);
      end
    end else if (char_code == CHAR_TAB) begin
      cx = tab_col;
    end else if (char_code == CHAR_CR) begin
      cx = '0;
    end else if (char_code == CHAR_LF) begin
      cx      = '0;
      row_inc = 1'b1;
    end else if (printable) begin
      step.write_cell = 1'b1;
      cx              = cx + CX_W'(1);
    end else begin
      // Other control codes and the high bytes leave the cursor alone.
    end
    if (cx >= CX_W'(COLUMNS)) begin
      cx      = '0;
      row_inc = 1'b1;
    end
    step.scroll = row_inc && (row == ROW_W'(ROWS - 1));
    row_next    = (row_inc && !step.scroll) ? row + ROW_W'(1) : row;
    col_next    = COL_W'(cx);
  end

endmodule
`default_nettype wire

// ----- sv/text_console_writer.sv -----
// A put word without scroll registers its result on acceptance; a read registers the
// memory cell, then its result in S_READ. Throughput: one put word per cycle while the
// result port keeps up; no word is taken during a read. A clear, and a put that scrolls,
// walk the buffer through the frame memory's single write port; no word taken meanwhile.
// Reset (synchronous, active high) homes the cursor and empties the result register;
// the frame buffer is not cleared and holds unknown cells until written.
`default_nettype none
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  char_code,
  input  wire logic [3:0]  bg_color,
  input  wire logic [3:0]  fg_color,
  input  wire logic [10:0] cell_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      cursor_pos,
  output logic [15:0]      read_data
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FIRST_LAST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SCROLL, S_FILL} state_t;

  state_t             state;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [ADDR_W-1:0]  walk;
  logic               read_hit;

  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;
  tcw_step_t          step;
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  next_addr;
  logic               accept;
  logic               index_ok;
  logic               load_result;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CELL_W-1:0]  wdata;
  logic               re;
  logic [ADDR_W-1:0]  raddr;
  logic [CELL_W-1:0]  rdata;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_cursor (
    .col      (cur_col),
    .row      (cur_row),
    .char_code(char_code),
    .col_next (col_next),
    .row_next (row_next),
    .step     (step)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign cur_addr  = ADDR_W'(cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col);
  assign next_addr = ADDR_W'(row_next) * ADDR_W'(COLUMNS) + ADDR_W'(col_next);
  assign index_ok  = {21'd0, cell_index} < 32'(CELLS);

  // A word loads the result register now unless it starts a read or a buffer walk.
  assign load_result = (accept && !(action == ACT_PUT && step.scroll) &&
                        action != ACT_CLEAR && action != ACT_READ) ||
                       (state == S_READ) ||
                       (state == S_FILL && walk == LAST_CELL);

  // Memory port steering. A scroll copies row r+1 into row r: the read address runs one row
  // and one cell ahead of the write, so the two never meet at one address.
  always_comb begin
    we    = 1'b0;
    waddr = walk;
    wdata = BLANK_CELL;
    re    = 1'b0;
    raddr = ADDR_W'(cell_index);
    unique case (state)
      S_IDLE: begin
        if (accept && action == ACT_PUT) begin
          we    = step.write_cell;
          waddr = cur_addr;
          wdata = {bg_color, fg_color, char_code};
          re    = step.scroll;
          raddr = ADDR_W'(COLUMNS);
        end else if (accept && action == ACT_READ) begin
          re = index_ok;
        end
      end
      S_SCROLL: begin
        we    = 1'b1;
        wdata = rdata;
        re    = (walk != LAST_COPY);
        raddr = walk + ADDR_W'(COLUMNS + 1);
      end
      S_FILL: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_col   <= '0;
      cur_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (action == ACT_PUT) begin
              cur_col <= col_next;
              cur_row <= row_next;
              if (step.scroll) begin
                state <= S_SCROLL;
                walk  <= '0;
              end else begin
                cursor_pos <= 11'(next_addr);
                read_data  <= '0;
              end
            end else if (action == ACT_CLEAR) begin
              cur_col <= '0;
              cur_row <= '0;
              state   <= S_FILL;
              walk    <= '0;
            end else if (action == ACT_READ) begin
              read_hit <= index_ok;
              state    <= S_READ;
            end else begin
              cursor_pos <= 11'(cur_addr);
              read_data  <= '0;
            end
          end
        end
        S_READ: begin
          cursor_pos <= 11'(cur_addr);
          read_data  <= read_hit ? rdata : '0;
          state      <= S_IDLE;
        end
        S_SCROLL: begin
          if (walk == LAST_COPY) begin
            walk  <= FIRST_LAST;
            state <= S_FILL;
          end else begin
            walk <= walk + ADDR_W'(1);
          end
        end
        S_FILL: begin
          if (walk == LAST_CELL) begin
            cursor_pos <= 11'(cur_addr);
            read_data  <= '0;
            state      <= S_IDLE;
          end else begin
            walk <= walk + ADDR_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result register is always empty while a word is in progress.
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("result pending while a word is in progress");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col < COL_W'(COLUMNS - 1) || cur_col == COL_W'(COLUMNS - 1)) &&
    (cur_row < ROW_W'(ROWS - 1) || cur_row == ROW_W'(ROWS - 1)))
    else $error("cursor outside the screen");

  a_clear_starts_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_CLEAR) |=>
      (state == S_FILL && walk == '0 && cur_col == '0 && cur_row == '0))
    else $error("clear did not start a fill from the home position");

  a_no_port_collision: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("read and write of one cell in the same cycle");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for text_console_writer: directed and random words.
module tb;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int TAB_STOP = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int RANDOM_WORDS = 1930;
  localparam int PHASE_ONE_END = 650;
  localparam int PHASE_TWO_END = 1300;
  localparam int PRESSURE_AT = 1500;
  localparam int HOLD_CYCLES = 400;
  // A clear or a scroll alone keeps both ports quiet while it walks the buffer.
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 10;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [7:0] CHAR_LAST_PRINTABLE = 8'h7F;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LAST_CONTROL = 8'h1F;
  localparam logic [7:0] CHAR_HIGH_FIRST = 8'h80;
  localparam logic [7:0] CHAR_HIGH_LAST = 8'hFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [3:0]  bg_color;
    logic [3:0]  fg_color;
    logic [10:0] cell_index;
  } console_word_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] read_data;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_PUT;
  logic [7:0]  char_code = 8'h00;
  logic [3:0]  bg_color = 4'h0;
  logic [3:0]  fg_color = 4'h0;
  logic [10:0] cell_index = 11'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] cursor_pos;
  logic [15:0] read_data;

  console_word_t   words_to_send[$];
  console_result_t expected_results[$];
  console_result_t due;

  logic [15:0] screen_model [0:CELL_COUNT-1];
  int cursor_col = 0;
  int cursor_row = 0;

  int accepted_words = 0;
  int checked_results = 0;
  int errors = 0;
  int put_count = 0;
  int clear_count = 0;
  int read_count = 0;
  int scroll_count = 0;
  int rx_hold = 0;
  bit pressure_done = 1'b0;
  int quiet_cycles = 0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .TAB_STOP(TAB_STOP)
  ) uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one word to the predicted console and returns the result it should give.
  function automatic console_result_t predict_console(console_word_t w);
    console_result_t r;
    r.read_data = '0;
    case (w.action)
      ACT_PUT: begin
        put_count++;
        if (w.char_code == CHAR_BACKSPACE && cursor_col != 0) begin
          cursor_col--;
        end else if (w.char_code == CHAR_TAB) begin
          cursor_col = (cursor_col / TAB_STOP + 1) * TAB_STOP;
        end else if (w.char_code == CHAR_CR) begin
          cursor_col = 0;
        end else if (w.char_code == CHAR_LF) begin
          cursor_col = 0;
          cursor_row++;
        end
        if (w.char_code >= CHAR_SPACE && w.char_code <= CHAR_LAST_PRINTABLE) begin
          screen_model[cursor_row * COLUMNS + cursor_col] =
            {w.bg_color, w.fg_color, w.char_code};
          cursor_col++;
        end
        if (cursor_col >= COLUMNS) begin
          cursor_col = 0;
          cursor_row++;
        end
        if (cursor_row >= ROWS) begin
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_model[i] = BLANK_CELL;
          cursor_row = ROWS - 1;
          scroll_count++;
        end
      end
      ACT_CLEAR: begin
        clear_count++;
        for (int i = 0; i < CELL_COUNT; i++)
          screen_model[i] = BLANK_CELL;
        cursor_col = 0;
        cursor_row = 0;
      end
      ACT_READ: begin
        read_count++;
        if (w.cell_index < CELL_COUNT)
          r.read_data = screen_model[w.cell_index];
      end
      default: begin
      end
    endcase
    r.cursor_pos = 11'(cursor_row * COLUMNS + cursor_col);
    return r;
  endfunction

  // Mostly text with colors, sprinkled with controls, high bytes, reads, unused actions and rare clears.
  function automatic console_word_t random_word();
    console_word_t w;
    int pick;
    int kind;
    w.action = ACT_PUT;
    w.char_code = 8'($urandom);
    w.bg_color = 4'($urandom);
    w.fg_color = 4'($urandom);
    w.cell_index = 11'($urandom);
    pick = $urandom_range(0, 999);
    kind = $urandom_range(0, 99);
    if (pick < 10) begin
      w.action = ACT_CLEAR;
    end else if (pick < 20) begin
      w.action = ACT_UNUSED;
    end else if (pick < 220) begin
      w.action = ACT_READ;
    end else if (kind < 6) begin
      w.char_code = CHAR_LF;
    end else if (kind < 10) begin
      w.char_code = CHAR_CR;
    end else if (kind < 15) begin
      w.char_code = CHAR_TAB;
    end else if (kind < 21) begin
      w.char_code = CHAR_BACKSPACE;
    end else if (kind < 24) begin
      w.char_code = 8'($urandom_range(CHAR_NUL, CHAR_LAST_CONTROL));
    end else if (kind < 28) begin
      w.char_code = 8'($urandom_range(CHAR_HIGH_FIRST, CHAR_HIGH_LAST));
    end else begin
      w.char_code = 8'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE));
    end
    return w;
  endfunction

  function automatic int idle_percent(bit sender);
    if (accepted_words < PHASE_ONE_END)
      return sender ? 7 : 52;
    if (accepted_words < PHASE_TWO_END)
      return sender ? 52 : 7;
    return 0;
  endfunction

  task automatic queue_word(logic [1:0] act, logic [7:0] code, logic [3:0] back,
                            logic [3:0] fore, logic [10:0] index);
    words_to_send.push_back('{act, code, back, fore, index});
  endtask

  // Sender: predicts each accepted word and offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_console(
          '{action, char_code, bg_color, fg_color, cell_index}));
        accepted_words <= accepted_words + 1;
      end
      if (!in_valid || in_ready) begin
        if (words_to_send.size() != 0 && $urandom_range(0, 99) >= idle_percent(1'b1)) begin
          console_word_t w;
          w = words_to_send.pop_front();
          action <= w.action;
          char_code <= w.char_code;
          bg_color <= w.bg_color;
          fg_color <= w.fg_color;
          cell_index <= w.cell_index;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: cursor_pos %0d read_data %h",
                   $time, cursor_pos, read_data);
        end else begin
          due = expected_results.pop_front();
          checked_results++;
          if (cursor_pos !== due.cursor_pos) begin
            errors++;
            $display("%0t: cursor_pos mismatch: expected %0d, actual %0d",
                     $time, due.cursor_pos, cursor_pos);
          end
          if (read_data !== due.read_data) begin
            errors++;
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, due.read_data, read_data);
          end
        end
      end
      // One long hold-off lets the block fill up and push back on the sender.
      if (!pressure_done && accepted_words >= PRESSURE_AT) begin
        rx_hold = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_percent(1'b0));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // The buffer is unknown until written, so the run opens with a clear.
    queue_word(ACT_CLEAR, CHAR_HIGH_LAST, 4'hF, 4'hF, 11'd2047);
    queue_word(ACT_READ, CHAR_NUL, 4'h0, 4'h0, 11'd0);
    queue_word(ACT_PUT, 8'h41, 4'h0, 4'hF, 11'd0);
    queue_word(ACT_PUT, CHAR_LAST_PRINTABLE, 4'hF, 4'h0, 11'd2047);
    queue_word(ACT_PUT, CHAR_SPACE, 4'h5, 4'hA, 11'd1);
    queue_word(ACT_PUT, CHAR_HIGH_LAST, 4'h3, 4'h3, 11'd0);
    queue_word(ACT_PUT, CHAR_HIGH_FIRST, 4'h3, 4'h3, 11'd0);
    queue_word(ACT_PUT, CHAR_NUL, 4'h3, 4'h3, 11'd0);
    queue_word(ACT_PUT, CHAR_LAST_CONTROL, 4'h3, 4'h3, 11'd0);
    queue_word(ACT_PUT, CHAR_BACKSPACE, 4'h0, 4'h0, 11'd0);
    queue_word(ACT_PUT, 8'h7E, 4'hC, 4'h3, 11'd0);
    queue_word(ACT_PUT, CHAR_TAB, 4'h0, 4'h0, 11'd0);
    queue_word(ACT_PUT, CHAR_CR, 4'h0, 4'h0, 11'd0);
    // Backspace at the first column leaves the cursor where it is.
    queue_word(ACT_PUT, CHAR_BACKSPACE, 4'h0, 4'h0, 11'd0);
    queue_word(ACT_PUT, CHAR_LF, 4'h0, 4'h0, 11'd0);
    queue_word(ACT_READ, CHAR_NUL, 4'h0, 4'h0, 11'd0);
    queue_word(ACT_READ, CHAR_NUL, 4'h0, 4'h0, 11'd1);
    queue_word(ACT_READ, CHAR_NUL, 4'h0, 4'h0, 11'd2);
    queue_word(ACT_READ, CHAR_NUL, 4'h0, 4'h0, 11'(CELL_COUNT - 1));
    queue_word(ACT_READ, CHAR_NUL, 4'h0, 4'h0, 11'(CELL_COUNT));
    queue_word(ACT_READ, CHAR_HIGH_LAST, 4'hF, 4'hF, 11'd2047);
    queue_word(ACT_UNUSED, CHAR_HIGH_LAST, 4'hF, 4'hF, 11'd2047);
    repeat (RANDOM_WORDS) words_to_send.push_back(random_word());

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (words_to_send.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d words: %0d puts, %0d clears, %0d reads, %0d scrolls",
             accepted_words, put_count, clear_count, read_count, scroll_count);
    $display("tb: %0d results checked, %0d mismatches", checked_results, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tcw_pkg.sv
sv/tcw_cell_ram.sv
sv/tcw_cursor.sv
sv/text_console_writer.sv
tb/tb.sv
